// ----- sv/psu_pkg.sv -----
// Shared constants, types and codes for the PNG scanline unfilter block.
package psu_pkg;

    localparam int MAX_ROW_BYTES = 8192;
    localparam int ADDR_W        = $clog2(MAX_ROW_BYTES);
    localparam int COL_W         = $clog2(MAX_ROW_BYTES + 1);
    localparam int CFG_W         = 14;
    localparam int DIST_W        = 4;
    localparam int RING_DEPTH    = 8;
    localparam int SLOT_W        = $clog2(RING_DEPTH);
    localparam int DIV_CNT_W     = $clog2(ADDR_W);
    localparam int CFG_IDX_W     = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BYTES = 1'd1;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } t_filter;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [SLOT_W-1:0] rem;
    } t_div_stat;

endpackage

// ----- sv/psu_in_if.sv -----
// Input stream channel: one byte of the inflated image stream per request.
interface psu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       image_start;

    modport source (output valid, output data_byte, output image_start, input ready);
    modport sink   (input valid, input data_byte, input image_start, output ready);
endinterface

// ----- sv/psu_out_if.sv -----
// Output stream channel: one reconstructed sample byte per request.
interface psu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       row_end;

    modport source (output valid, output out_byte, output row_end, input ready);
    modport sink   (input valid, input out_byte, input row_end, output ready);
endinterface

// ----- sv/psu_line_ram.sv -----
// Previous-row line buffer: one write port, one registered read port, write forwarding.
module psu_line_ram
    import psu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] mem [MAX_ROW_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/psu_slot_div.sv -----
// Bit-serial remainder unit: column modulo pixel distance, one bit per cycle.
module psu_slot_div
    import psu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ADDR_W-1:0] i_x,
    input  logic [DIST_W-1:0] i_dist,
    output t_div_stat         o_stat
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [ADDR_W-1:0]    r_x;
    logic [DIST_W-1:0]    r_dist;
    logic [SLOT_W-1:0]    r_rem;
    logic [SLOT_W:0]      trial;
    logic [SLOT_W:0]      n_rem;

    always_comb begin
        trial = {r_rem, r_x[ADDR_W-1]};
        if (trial >= (SLOT_W+1)'(r_dist)) begin
            n_rem = trial - (SLOT_W+1)'(r_dist);
        end else begin
            n_rem = trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(ADDR_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_x;
            r_dist <= i_dist;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_x   <= {r_x[ADDR_W-2:0], 1'b0};
            r_rem <= n_rem[SLOT_W-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_stat.rem  = r_rem;

endmodule

// ----- sv/png_scanline_unfilter_unit.sv -----
// PNG scanline unfilter: reconstructs None/Sub/Up/Average/Paeth rows from a byte stream.
//
// i_in carries the inflated stream, one byte per request. image_start marks the
// filter byte of an image's first row. Each row is a filter byte followed by
// row_bytes samples; a filter byte yields nothing, each sample yields one
// request on o_out, row_end high on the last sample of the row.
// Throughput is one byte per cycle unless o_out stalls or a slot recompute
// runs. The previous row sits in a line buffer with a registered read; the
// entry for the next column is prefetched while the current byte is taken,
// so a result appears on o_out in the cycle after its sample is accepted.
// o_out is a single output register: a stalled receiver holds it. i_in stalls
// when that register is full and not being taken, and during a slot recompute.
// Configuration: i_cfg_we with i_cfg_index 0 = row_bytes, 1 = pixel_bytes,
// written while no row is in flight or mid-row between bytes. After a write
// i_in.ready stays low while the ring slot is recomputed bit-serially as
// column mod pixel distance.
// Reset (synchronous, active low) returns to awaiting a first-row filter byte
// with row_bytes = pixel_bytes = 1; the line buffer is not cleared.
module png_scanline_unfilter_unit
    import psu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    psu_in_if.sink               i_in,
    psu_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int WIDE_W = (CFG_W > COL_W) ? CFG_W : COL_W;

    logic [CFG_W-1:0]  r_row_bytes;
    logic [DIST_W-1:0] r_pixel_bytes;
    logic [COL_W-1:0]  r_column;
    logic [COL_W-1:0]  n_column;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;
    t_filter           r_filter;
    logic              r_await;
    logic              r_first;
    logic              r_pend;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_end;
    logic [7:0]        r_rcur [RING_DEPTH];
    logic [7:0]        r_rpri [RING_DEPTH];

    logic [COL_W-1:0]  len_eff;
    logic [DIST_W-1:0] dist_eff;
    logic [ADDR_W-1:0] x;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        ram_rdata;
    logic              accept;
    logic              awaiting;
    logic              sample;
    logic              far;
    logic              row_last;
    logic [7:0]        a;
    logic [7:0]        b;
    logic [7:0]        c;
    logic [8:0]        ab_sum;
    logic [7:0]        v;
    logic              div_start;
    t_div_stat         div_stat;

    function automatic logic [ADDR_W-1:0] clamp_col(input logic [COL_W-1:0] col,
                                                    input logic [COL_W-1:0] len);
        logic [COL_W-1:0] last;
        last = len - COL_W'(1);
        if (col >= len) begin
            return last[ADDR_W-1:0];
        end
        return col[ADDR_W-1:0];
    endfunction

    function automatic logic [7:0] paeth(input logic [7:0] pa_a, input logic [7:0] pa_b,
                                         input logic [7:0] pa_c);
        logic signed [10:0] da;
        logic signed [10:0] db;
        logic signed [10:0] dc;
        logic        [10:0] ea;
        logic        [10:0] eb;
        logic        [10:0] ec;
        da = $signed({3'b0, pa_b}) - $signed({3'b0, pa_c});
        db = $signed({3'b0, pa_a}) - $signed({3'b0, pa_c});
        dc = $signed({3'b0, pa_a}) + $signed({3'b0, pa_b}) - $signed({2'b0, pa_c, 1'b0});
        ea = (da < 0) ? 11'(-da) : 11'(da);
        eb = (db < 0) ? 11'(-db) : 11'(db);
        ec = (dc < 0) ? 11'(-dc) : 11'(dc);
        if (ea <= eb && ea <= ec) begin
            return pa_a;
        end
        if (eb <= ec) begin
            return pa_b;
        end
        return pa_c;
    endfunction

    always_comb begin
        if (r_row_bytes == '0) begin
            len_eff = COL_W'(1);
        end else if (WIDE_W'(r_row_bytes) > WIDE_W'(MAX_ROW_BYTES)) begin
            len_eff = COL_W'(MAX_ROW_BYTES);
        end else begin
            len_eff = COL_W'(r_row_bytes);
        end
        if (r_pixel_bytes == '0) begin
            dist_eff = DIST_W'(1);
        end else if (r_pixel_bytes > DIST_W'(RING_DEPTH)) begin
            dist_eff = DIST_W'(RING_DEPTH);
        end else begin
            dist_eff = r_pixel_bytes;
        end
    end

    assign x        = clamp_col(r_column, len_eff);
    assign accept   = i_in.valid && i_in.ready;
    assign awaiting = r_await || i_in.image_start;
    assign sample   = accept && !awaiting;
    assign far      = x >= ADDR_W'(dist_eff);
    assign row_last = (COL_W'(x) + COL_W'(1)) >= len_eff;

    assign a      = far ? r_rcur[r_slot] : 8'd0;
    assign b      = r_first ? 8'd0 : ram_rdata;
    assign c      = (!r_first && far) ? r_rpri[r_slot] : 8'd0;
    assign ab_sum = {1'b0, a} + {1'b0, b};

    always_comb begin
        unique case (r_filter)
            FILT_SUB:   v = i_in.data_byte + a;
            FILT_UP:    v = i_in.data_byte + b;
            FILT_AVG:   v = i_in.data_byte + ab_sum[8:1];
            FILT_PAETH: v = i_in.data_byte + paeth(a, b, c);
            default:    v = i_in.data_byte;
        endcase
    end

    always_comb begin
        n_column = r_column;
        n_slot   = r_slot;
        if (div_stat.done) begin
            n_slot = div_stat.rem;
        end else if (accept) begin
            if (awaiting || row_last) begin
                n_column = '0;
                n_slot   = '0;
            end else begin
                n_column = COL_W'(x) + COL_W'(1);
                n_slot   = (COL_W'(r_slot) == COL_W'(dist_eff - DIST_W'(1))) ? '0
                                                                      : r_slot + 1'b1;
            end
        end
    end

    assign rd_addr   = clamp_col(n_column, len_eff);
    assign div_start = r_pend;

    psu_line_ram u_line_ram (
        .i_clk   (i_clk),
        .i_we    (sample),
        .i_waddr (x),
        .i_wdata (v),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    psu_slot_div u_slot_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_x     (x),
        .i_dist  (dist_eff),
        .o_stat  (div_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bytes   <= CFG_W'(1);
            r_pixel_bytes <= DIST_W'(1);
            r_column      <= '0;
            r_slot        <= '0;
            r_filter      <= FILT_NONE;
            r_await       <= 1'b1;
            r_first       <= 1'b1;
            r_pend        <= 1'b0;
            r_out_valid   <= 1'b0;
            for (int i = 0; i < RING_DEPTH; i++) begin
                r_rcur[i] <= 8'd0;
                r_rpri[i] <= 8'd0;
            end
        end else begin
            r_column <= n_column;
            r_slot   <= n_slot;
            r_pend   <= i_cfg_we;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_ROW_BYTES) begin
                    r_row_bytes <= i_cfg_data;
                end else if (i_cfg_index == CFG_PIXEL_BYTES) begin
                    r_pixel_bytes <= i_cfg_data[DIST_W-1:0];
                end
            end
            if (accept && awaiting) begin
                r_filter <= (i_in.data_byte <= 8'd4) ? t_filter'(i_in.data_byte[2:0])
                                                     : FILT_NONE;
                r_await  <= 1'b0;
                r_first  <= r_first || i_in.image_start;
            end else if (sample) begin
                r_rcur[r_slot] <= v;
                r_rpri[r_slot] <= b;
                if (row_last) begin
                    r_await <= 1'b1;
                    r_first <= 1'b0;
                end
            end
            if (sample) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (sample) begin
            r_out_byte <= v;
            r_out_end  <= row_last;
        end
    end

    assign i_in.ready     = !r_pend && !div_stat.busy && !div_stat.done
                            && (!r_out_valid || o_out.ready);
    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.row_end  = r_out_end;

`ifndef SYNTHESIS
    a_cfg_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !i_in.ready)
        else $error("input taken right after a configuration write");

    a_div_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_stat.busy || div_stat.done) |-> !i_in.ready)
        else $error("input taken while slot recompute is running");

    a_row_end_awaits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sample && row_last) |=> (r_await && r_column == '0))
        else $error("row end did not return to filter byte");

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> (COL_W'(r_slot) < COL_W'(dist_eff)))
        else $error("ring slot beyond pixel distance");
`endif

endmodule

// ----- verif/tb_png_scanline_unfilter_unit.sv -----
// Testbench for png_scanline_unfilter_unit: directed table, random rows, predicted samples.
module tb_png_scanline_unfilter_unit;
    import psu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       row_end;
    } t_sample;

    typedef enum logic {STEP_ITEM, STEP_REG} t_step_kind;

    typedef struct packed {
        t_step_kind           kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_val;
        logic [7:0]           data;
        logic                 start;
        logic                 typed;
        logic [7:0]           exp_byte;
        logic                 exp_end;
    } t_step;

    localparam int N_DIRECTED   = 34;
    localparam int RANDOM_ITEMS = 560;
    localparam int WIDE_ROW_N   = 48;

    localparam t_step DIRECTED [N_DIRECTED] = '{
        '{STEP_ITEM, CFG_ROW_BYTES,   14'd0, 8'(FILT_NONE),  1'b0, 1'b0, 8'h00, 1'b0},
        '{STEP_ITEM, CFG_ROW_BYTES,   14'd0, 8'hFF,          1'b0, 1'b1, 8'hFF, 1'b1},
        '{STEP_ITEM, CFG_ROW_BYTES,   14'd0, 8'(FILT_UP),    1'b0, 1'b0, 8'h00, 1'b0},
        '{STEP_ITEM, CFG_ROW_BYTES,   14'd0, 8'h01,          1'b0, 1'b1, 8'h00, 1'b1},
        '{STEP_REG,  CFG_ROW_BYTES,   14'd0, 8'h00,          1'b0, 1'b0, 8'h00, 1'b0},
        '{STEP_ITEM, CFG_ROW_BYTES,   14'd0, 8'h07,          1'b1, 1'b0, 8'h00, 1'b0},
        '{STEP_ITEM, CFG_ROW_BYTES,   14'd0, 8'h80,          1'b0, 1'b1, 8'h80, 1'b1},
        '{STEP_REG,  CFG_ROW_BYTES,   14'd3, 8'h00,          1'b0, 1'b0, 8'h00, 1'b0},
        '{STEP_REG,  CFG_PIXEL_BYTES, 14'd0, 8'h00,          1'b0, 1'b0, 8'h00, 1'b0},
        '{STEP_ITEM, CFG_ROW_BYTES,   14'd0, 8'(FILT_SUB),   1'b1, 1'b0, 8'h00, 1'b0},
        '{STEP_ITEM, CFG_ROW_BYTES,   14'd0, 8'hF0,          1'b0, 1'b1, 8'hF0, 1'b0},
        '{STEP_ITEM, CFG_ROW_BYTES,   14'd0, 8'h20,          1'b0, 1'b1, 8'h10, 1'b0},
        '{STEP_ITEM, CFG_ROW_BYTES,   14'd0, 8'hFF,          1'b0, 1'b1, 8'h0F, 1'b1},
        '{STEP_ITEM, CFG_ROW_BYTES,   14'd0, 8'(FILT_PAETH), 1'b0, 1'b0, 8'h00, 1'b0},
        '{STEP_ITEM, CFG_ROW_BYTES,   14'd0, 8'h00,          1'b0, 1'b0, 8'h00, 1'b0},
        '{STEP_ITEM, CFG_ROW_BYTES,   14'd0, 8'h7F,          1'b0, 1'b0, 8'h00, 1'b0},
        '{STEP_ITEM, CFG_ROW_BYTES,   14'd0, 8'h80,          1'b0, 1'b0, 8'h00, 1'b0},
        '{STEP_ITEM, CFG_ROW_BYTES,   14'd0, 8'(FILT_AVG),   1'b0, 1'b0, 8'h00, 1'b0},
        '{STEP_ITEM, CFG_ROW_BYTES,   14'd0, 8'hFF,          1'b0, 1'b0, 8'h00, 1'b0},
        '{STEP_ITEM, CFG_ROW_BYTES,   14'd0, 8'h01,          1'b0, 1'b0, 8'h00, 1'b0},
        '{STEP_ITEM, CFG_ROW_BYTES,   14'd0, 8'h00,          1'b0, 1'b0, 8'h00, 1'b0},
        '{STEP_REG,  CFG_ROW_BYTES,   14'd5, 8'h00,          1'b0, 1'b0, 8'h00, 1'b0},
        '{STEP_REG,  CFG_PIXEL_BYTES, 14'd2, 8'h00,          1'b0, 1'b0, 8'h00, 1'b0},
        '{STEP_ITEM, CFG_ROW_BYTES,   14'd0, 8'(FILT_SUB),   1'b1, 1'b0, 8'h00, 1'b0},
        '{STEP_ITEM, CFG_ROW_BYTES,   14'd0, 8'h33,          1'b0, 1'b0, 8'h00, 1'b0},
        '{STEP_ITEM, CFG_ROW_BYTES,   14'd0, 8'h44,          1'b0, 1'b0, 8'h00, 1'b0},
        '{STEP_ITEM, CFG_ROW_BYTES,   14'd0, 8'h55,          1'b0, 1'b0, 8'h00, 1'b0},
        // shrink the row mid-row: the next sample closes it
        '{STEP_REG,  CFG_ROW_BYTES,   14'd2, 8'h00,          1'b0, 1'b0, 8'h00, 1'b0},
        '{STEP_ITEM, CFG_ROW_BYTES,   14'd0, 8'h66,          1'b0, 1'b0, 8'h00, 1'b0},
        '{STEP_ITEM, CFG_ROW_BYTES,   14'd0, 8'(FILT_UP),    1'b0, 1'b0, 8'h00, 1'b0},
        '{STEP_ITEM, CFG_ROW_BYTES,   14'd0, 8'h11,          1'b0, 1'b0, 8'h00, 1'b0},
        // image start abandons the partial row
        '{STEP_ITEM, CFG_ROW_BYTES,   14'd0, 8'(FILT_PAETH), 1'b1, 1'b0, 8'h00, 1'b0},
        '{STEP_ITEM, CFG_ROW_BYTES,   14'd0, 8'h99,          1'b0, 1'b0, 8'h00, 1'b0},
        '{STEP_ITEM, CFG_ROW_BYTES,   14'd0, 8'hAA,          1'b0, 1'b0, 8'h00, 1'b0}
    };

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    psu_in_if  in_if();
    psu_out_if out_if();

    png_scanline_unfilter_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor state
    logic [7:0]       line_buf     [MAX_ROW_BYTES];
    bit               line_written [MAX_ROW_BYTES];
    logic [7:0]       ring_cur     [RING_DEPTH];
    logic [7:0]       ring_prior   [RING_DEPTH];
    int unsigned      col;
    t_filter          filt;
    bit               want_filter;
    bit               top_row;
    logic [CFG_W-1:0] row_q;
    logic [DIST_W-1:0] pix_q;

    t_sample expected_samples [$];
    int      bad_count;
    int      items_sent;
    int      in_gap_max;
    int      out_gap_max;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("FAILURE");
        $finish;
    end

    function automatic int unsigned eff_len();
        if (row_q == 0) return 1;
        if (row_q > MAX_ROW_BYTES) return MAX_ROW_BYTES;
        return row_q;
    endfunction

    function automatic int unsigned clamped_col();
        int unsigned len;
        len = eff_len();
        return (col >= len) ? len - 1 : col;
    endfunction

    function automatic void unfilter_byte(input logic [7:0] d, input bit s,
                                          output bit produced, output logic [7:0] v,
                                          output bit last);
        int unsigned len, span, x, slot;
        int a, b, c, p, pa, pb, pc, pred;
        produced = 1'b0;
        v        = '0;
        last     = 1'b0;
        if (s) begin
            top_row     = 1'b1;
            want_filter = 1'b1;
            col         = 0;
        end
        if (want_filter) begin
            filt        = (d <= 8'd4) ? t_filter'(d[2:0]) : FILT_NONE;
            want_filter = 1'b0;
            col         = 0;
            return;
        end
        len  = eff_len();
        span = (pix_q == 0) ? 1 : ((pix_q > RING_DEPTH) ? RING_DEPTH : pix_q);
        x    = clamped_col();
        slot = x % span;
        a = (x >= span) ? int'(ring_cur[slot]) : 0;
        b = top_row ? 0 : int'(line_buf[x]);
        c = (!top_row && x >= span) ? int'(ring_prior[slot]) : 0;
        case (filt)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = (a + b) / 2;
            FILT_PAETH: begin
                p  = a + b - c;
                pa = (p > a) ? p - a : a - p;
                pb = (p > b) ? p - b : b - p;
                pc = (p > c) ? p - c : c - p;
                if (pa <= pb && pa <= pc) pred = a;
                else if (pb <= pc)        pred = b;
                else                      pred = c;
            end
            default:    pred = 0;
        endcase
        v = d + pred[7:0];
        ring_prior[slot] = b[7:0];
        ring_cur[slot]   = v;
        line_buf[x]      = v;
        line_written[x]  = 1'b1;
        produced = 1'b1;
        if (x + 1 >= len) begin
            last        = 1'b1;
            col         = 0;
            want_filter = 1'b1;
            top_row     = 1'b0;
        end else begin
            col = x + 1;
        end
    endfunction

    task automatic send_byte(input logic [7:0] d, input bit s, input bit typed,
                             input t_sample typed_val);
        int         gap;
        bit         st, produced, last;
        logic [7:0] v;
        st = s;
        // never let a sample read a line buffer entry that was never written
        if (!st && !want_filter && !top_row && !line_written[clamped_col()]) st = 1'b1;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.data_byte   <= d;
        in_if.image_start <= st;
        do @(posedge i_clk); while (!(in_if.valid === 1'b1 && in_if.ready === 1'b1));
        items_sent++;
        unfilter_byte(d, st, produced, v, last);
        if (produced) expected_samples.push_back(typed ? typed_val : t_sample'{v, last});
    endtask

    task automatic send_row(input logic [7:0] filt_byte, input bit s, input int n,
                            input bit noisy);
        send_byte(filt_byte, s, 1'b0, '0);
        repeat (n) begin
            send_byte(8'($urandom_range(0, 255)), noisy && $urandom_range(0, 39) == 0,
                      1'b0, '0);
        end
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        if (idx == CFG_ROW_BYTES)        row_q = val;
        else if (idx == CFG_PIXEL_BYTES) pix_q = val[DIST_W-1:0];
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // result side: random back-pressure and comparison
    initial begin
        int      stall;
        t_sample got, want;
        out_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = $urandom_range(0, out_gap_max);
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_if.valid === 1'b1 && out_if.ready === 1'b1));
            got = '{out_if.out_byte, out_if.row_end};
            if (expected_samples.size() == 0) begin
                bad_count++;
                if (bad_count <= 10)
                    $display("unexpected sample: out_byte=%h row_end=%b",
                             got.out_byte, got.row_end);
            end else begin
                want = expected_samples.pop_front();
                if (got.out_byte !== want.out_byte || got.row_end !== want.row_end) begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("sample mismatch: out_byte exp %h got %h, row_end exp %b got %b",
                                 want.out_byte, got.out_byte, want.row_end, got.row_end);
                end
            end
        end
    end

    initial begin
        int               start_count, rows, n, len;
        bit               new_image;
        logic [7:0]       fb;
        logic [DIST_W-1:0] pix;
        in_if.valid       <= 1'b0;
        in_if.data_byte   <= '0;
        in_if.image_start <= 1'b0;
        foreach (ring_cur[i]) begin
            ring_cur[i]   = '0;
            ring_prior[i] = '0;
        end
        col         = 0;
        filt        = FILT_NONE;
        want_filter = 1'b1;
        top_row     = 1'b1;
        row_q       = 1;
        pix_q       = 1;
        bad_count   = 0;
        items_sent  = 0;
        in_gap_max  = 9;
        out_gap_max = 9;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == STEP_REG) begin
                wait_idle();
                set_reg(DIRECTED[i].reg_idx, DIRECTED[i].reg_val);
            end else begin
                send_byte(DIRECTED[i].data, DIRECTED[i].start, DIRECTED[i].typed,
                          t_sample'{DIRECTED[i].exp_byte, DIRECTED[i].exp_end});
            end
        end

        // widest rows and distance, full rate
        wait_idle();
        in_gap_max  = 0;
        out_gap_max = 0;
        set_reg(CFG_ROW_BYTES, 14'd8192);
        set_reg(CFG_PIXEL_BYTES, 14'd15);
        send_row(8'($urandom_range(0, 4)), 1'b1, WIDE_ROW_N, 1'b0);
        wait_idle();
        set_reg(CFG_ROW_BYTES, 14'h3FFF);
        send_row(8'(FILT_PAETH), 1'b0, WIDE_ROW_N, 1'b0);

        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            wait_idle();
            in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 9;
            out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 15))
                    0:       set_reg(CFG_ROW_BYTES, 14'd0);
                    1:       set_reg(CFG_ROW_BYTES, 14'd1);
                    2:       set_reg(CFG_ROW_BYTES, 14'($urandom_range(40, 120)));
                    default: set_reg(CFG_ROW_BYTES, 14'($urandom_range(2, 16)));
                endcase
            end
            if ($urandom_range(0, 3) != 0) begin
                pix = 4'($urandom_range(0, 15));
                set_reg(CFG_PIXEL_BYTES, {10'($urandom_range(0, 1023)), pix});
            end
            new_image = ($urandom_range(0, 5) != 0);
            rows      = $urandom_range(1, 6);
            for (int r = 0; r < rows; r++) begin
                fb  = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, 4));
                len = eff_len();
                n   = ($urandom_range(0, 11) == 0) ? $urandom_range(0, len - 1) : len;
                send_row(fb, (r == 0 && new_image) || $urandom_range(0, 19) == 0, n, 1'b1);
            end
        end

        in_if.valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (bad_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
